/* design/cgbp_pkg.sv */
// ----------------------------------------------------------------------------
// cgbp_pkg: shared types and constants of the clipped glyph blit planner
// Command and status words between the controller and the datapath, and
// the configuration register indexes.
// ----------------------------------------------------------------------------
package cgbp_pkg;

  localparam int unsigned CoordW   = 10;
  localparam int unsigned PosW     = 11;
  localparam int unsigned SizeW    = 7;
  localparam int unsigned AddrW    = 16;
  localparam int unsigned AlphaW   = 4;
  localparam int unsigned CfgIdxW  = 1;

  localparam logic [CfgIdxW-1:0] CFG_SCREEN_WIDTH  = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_SCREEN_HEIGHT = 1'b1;

  localparam logic [CoordW-1:0] SCREEN_WIDTH_RESET  = 10'd240;
  localparam logic [CoordW-1:0] SCREEN_HEIGHT_RESET = 10'd320;

  typedef struct packed {
    logic load;
    logic clip;
    logic size;
    logic mult;
    logic addr;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic visible;
    logic last_row;
    logic out_free;
  } status_t;

endpackage

/* design/cgbp_ctrl.sv */
// ----------------------------------------------------------------------------
// cgbp_ctrl: sequencing controller
// Accepts one placement, steps the datapath through clipping, size, multiply
// and address stages; a visible one gets one write command per output word.
// ----------------------------------------------------------------------------
module cgbp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  cgbp_pkg::status_t status_i,
  output cgbp_pkg::cmd_t    cmd_o
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_CLIP = 6'b000010,
    ST_SIZE = 6'b000100,
    ST_MULT = 6'b001000,
    ST_ADDR = 6'b010000,
    ST_EMIT = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CLIP;
        end
      end
      ST_CLIP: begin
        cmd_o.clip = 1'b1;
        state_d    = ST_SIZE;
      end
      ST_SIZE: begin
        cmd_o.size = 1'b1;
        state_d    = ST_MULT;
      end
      ST_MULT: begin
        // drop placements with no visible pixel
        if (status_i.visible) begin
          cmd_o.mult = 1'b1;
          state_d    = ST_ADDR;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_ADDR: begin
        cmd_o.addr = 1'b1;
        state_d    = ST_EMIT;
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.last_row) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

/* design/cgbp_datapath.sv */
// ----------------------------------------------------------------------------
// cgbp_datapath: clipping and address datapath
// Holds the placement and screen size, clips the glyph in registered steps,
// forms the source address and drives the output word register.
// ----------------------------------------------------------------------------
module cgbp_datapath #(
  parameter int unsigned MAX_GLYPH_HEIGHT = 64,
  parameter int unsigned ALPHA_LEVELS     = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [cgbp_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [cgbp_pkg::CoordW-1:0]         cfg_wdata_i,
  input  cgbp_pkg::cmd_t                      cmd_i,
  output cgbp_pkg::status_t                   status_o,
  input  logic signed [cgbp_pkg::PosW-1:0]    pos_x_i,
  input  logic signed [cgbp_pkg::PosW-1:0]    pos_y_i,
  input  logic [cgbp_pkg::SizeW-1:0]          glyph_width_i,
  input  logic [cgbp_pkg::SizeW-1:0]          glyph_height_i,
  input  logic [cgbp_pkg::AddrW-1:0]          bitmap_offset_i,
  input  logic [cgbp_pkg::AlphaW-1:0]         alpha_level_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [cgbp_pkg::CoordW-1:0]         dest_x_o,
  output logic [cgbp_pkg::CoordW-1:0]         dest_y_o,
  output logic [cgbp_pkg::SizeW-1:0]          rect_width_o,
  output logic [cgbp_pkg::SizeW-1:0]          rect_height_o,
  output logic [cgbp_pkg::AddrW-1:0]          source_address_o,
  output logic                                half_byte_start_o,
  output logic [cgbp_pkg::AlphaW-1:0]         palette_select_o,
  output logic                                last_command_o
);

  localparam logic [cgbp_pkg::SizeW-1:0]  HMax   = cgbp_pkg::SizeW'(MAX_GLYPH_HEIGHT);
  localparam logic [cgbp_pkg::AlphaW:0]   ALevel = (cgbp_pkg::AlphaW + 1)'(ALPHA_LEVELS);
  localparam logic [cgbp_pkg::AlphaW-1:0] AMax   = cgbp_pkg::AlphaW'(ALPHA_LEVELS - 1);

  logic [cgbp_pkg::CoordW-1:0] sw_q, sh_q;

  logic signed [10:0] x_q, y_q;
  logic [6:0]  w_q, h_q;
  logic [15:0] off_q;
  logic [3:0]  pal_q;

  logic signed [11:0] xe_q, ye_q;
  logic [9:0]  sx_q, sy_q;
  logic [10:0] skipx_q, skipy_q;
  logic [6:0]  rowb_q;

  logic signed [11:0] xm, ym, xo_raw, yo_raw;
  logic [6:0]  xo_q, yo_q;
  logic        vis_q, full_q;

  logic [17:0] prod_full;
  logic [15:0] prod_q;

  logic [15:0] src_q;
  logic [9:0]  dy_q;
  logic [6:0]  hout_q;
  logic        half_q;
  logic [6:0]  rows_left_q;

  logic        out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q <= cgbp_pkg::SCREEN_WIDTH_RESET;
      sh_q <= cgbp_pkg::SCREEN_HEIGHT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cgbp_pkg::CFG_SCREEN_WIDTH:  sw_q <= cfg_wdata_i;
        cgbp_pkg::CFG_SCREEN_HEIGHT: sh_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q   <= pos_x_i;
      y_q   <= pos_y_i;
      w_q   <= glyph_width_i;
      h_q   <= (glyph_height_i > HMax) ? HMax : glyph_height_i;
      off_q <= bitmap_offset_i;
      pal_q <= ({1'b0, alpha_level_i} >= ALevel) ? AMax : alpha_level_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clip) begin
      xe_q    <= $signed({x_q[10], x_q}) + $signed({5'b0, w_q});
      ye_q    <= $signed({y_q[10], y_q}) + $signed({5'b0, h_q});
      sx_q    <= x_q[10] ? 10'd0 : x_q[9:0];
      sy_q    <= y_q[10] ? 10'd0 : y_q[9:0];
      skipx_q <= x_q[10] ? (~x_q[10:0] + 11'd1) : 11'd0;
      skipy_q <= y_q[10] ? (~y_q[10:0] + 11'd1) : 11'd0;
      rowb_q  <= {1'b0, w_q[6:1]} + {6'b0, w_q[0]};
    end
  end

  always_comb begin
    xm     = ($signed({2'b00, sw_q}) < xe_q) ? $signed({2'b00, sw_q}) : xe_q;
    ym     = ($signed({2'b00, sh_q}) < ye_q) ? $signed({2'b00, sh_q}) : ye_q;
    xo_raw = xm - $signed({2'b00, sx_q});
    yo_raw = ym - $signed({2'b00, sy_q});
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.size) begin
      xo_q   <= (xo_raw > 12'sd0) ? xo_raw[6:0] : 7'd0;
      yo_q   <= (yo_raw > 12'sd0) ? yo_raw[6:0] : 7'd0;
      vis_q  <= (xo_raw > 12'sd0) && (yo_raw > 12'sd0);
      full_q <= (xo_raw == $signed({5'b0, w_q}));
    end
  end

  assign prod_full = {7'b0, skipy_q} * {11'b0, rowb_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.mult) begin
      prod_q <= prod_full[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.addr) begin
      src_q  <= off_q + prod_q + (full_q ? 16'd0 : {6'b0, skipx_q[10:1]});
      dy_q   <= sy_q;
      hout_q <= full_q ? yo_q : 7'd1;
      half_q <= full_q ? 1'b0 : skipx_q[0];
    end else if (cmd_i.emit) begin
      src_q <= src_q + {9'b0, rowb_q};
      dy_q  <= dy_q + 10'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_left_q <= '0;
    end else if (cmd_i.addr) begin
      rows_left_q <= full_q ? 7'd1 : yo_q;
    end else if (cmd_i.emit) begin
      rows_left_q <= rows_left_q - 7'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      dest_x_o          <= sx_q;
      dest_y_o          <= dy_q;
      rect_width_o      <= xo_q;
      rect_height_o     <= hout_q;
      source_address_o  <= src_q;
      half_byte_start_o <= half_q;
      palette_select_o  <= pal_q;
      last_command_o    <= (rows_left_q == 7'd1);
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o.visible  = vis_q;
  assign status_o.last_row = (rows_left_q == 7'd1);
  assign status_o.out_free = !out_valid_q || !out_stall_i;

endmodule

/* design/clipped_glyph_blit_planner_core.sv */
// ----------------------------------------------------------------------------
// clipped_glyph_blit_planner_core: glyph clipping and blit command planner
// Usage: one placement word enters on the in channel (in_valid_i/in_stall_o)
// while the block is idle; write command words leave on the out channel
// (out_valid_o/out_stall_i), last_command_o marking the final one.
// Screen size is set through cfg_we_i/cfg_idx_i/cfg_wdata_i while idle.
// After acceptance the clip, size, multiply and address steps each take one
// controller state, then the emit state registers each command word.
// Output: a fully wide glyph gives one command word, an edge-clipped glyph
// one word per visible row, one row per cycle from the emit state while the
// output is free; a glyph with no visible pixel gives no word.
// The next placement is taken while the last word still waits in the
// output register.
// Reset: clears the controller, the output valid and sets the screen to
// 240 by 320 pixels.
// Stall: a stalled output word holds; row emission pauses until it is taken.
// ----------------------------------------------------------------------------
module clipped_glyph_blit_planner_core #(
  parameter int unsigned MAX_GLYPH_HEIGHT = 64,
  parameter int unsigned ALPHA_LEVELS     = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [cgbp_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [cgbp_pkg::CoordW-1:0]         cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [cgbp_pkg::PosW-1:0]    pos_x_i,
  input  logic signed [cgbp_pkg::PosW-1:0]    pos_y_i,
  input  logic [cgbp_pkg::SizeW-1:0]          glyph_width_i,
  input  logic [cgbp_pkg::SizeW-1:0]          glyph_height_i,
  input  logic [cgbp_pkg::AddrW-1:0]          bitmap_offset_i,
  input  logic [cgbp_pkg::AlphaW-1:0]         alpha_level_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [cgbp_pkg::CoordW-1:0]         dest_x_o,
  output logic [cgbp_pkg::CoordW-1:0]         dest_y_o,
  output logic [cgbp_pkg::SizeW-1:0]          rect_width_o,
  output logic [cgbp_pkg::SizeW-1:0]          rect_height_o,
  output logic [cgbp_pkg::AddrW-1:0]          source_address_o,
  output logic                                half_byte_start_o,
  output logic [cgbp_pkg::AlphaW-1:0]         palette_select_o,
  output logic                                last_command_o
);

  cgbp_pkg::cmd_t    cmd;
  cgbp_pkg::status_t status;

  cgbp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  cgbp_datapath #(
    .MAX_GLYPH_HEIGHT (MAX_GLYPH_HEIGHT),
    .ALPHA_LEVELS     (ALPHA_LEVELS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .cmd_i             (cmd),
    .status_o          (status),
    .pos_x_i           (pos_x_i),
    .pos_y_i           (pos_y_i),
    .glyph_width_i     (glyph_width_i),
    .glyph_height_i    (glyph_height_i),
    .bitmap_offset_i   (bitmap_offset_i),
    .alpha_level_i     (alpha_level_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .dest_x_o          (dest_x_o),
    .dest_y_o          (dest_y_o),
    .rect_width_o      (rect_width_o),
    .rect_height_o     (rect_height_o),
    .source_address_o  (source_address_o),
    .half_byte_start_o (half_byte_start_o),
    .palette_select_o  (palette_select_o),
    .last_command_o    (last_command_o)
  );

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("block still idle after taking a placement");

  a_emit_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> (!out_valid_o || !out_stall_i))
    else $error("output word overwritten while stalled");

  a_no_emit_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !cmd.emit)
    else $error("command issued while idle");

  a_last_ends_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit && status.last_row) |=> !in_stall_o)
    else $error("controller busy after the final word");
`endif

endmodule

/* sim/cgbp_blit_checker.sv */
// ----------------------------------------------------------------------------
// cgbp_blit_checker: command predictor and scoreboard for the blit planner
// Watches the config port and both channels. Every accepted placement word
// is clipped against the tracked screen size and the write command words it
// must cause are queued. Every accepted command word is compared field by
// field with the oldest queued one. Mismatch and pending counts go to the top.
// ----------------------------------------------------------------------------
module cgbp_blit_checker #(
  parameter int unsigned MAX_GLYPH_HEIGHT = 64,
  parameter int unsigned ALPHA_LEVELS     = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [cgbp_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [cgbp_pkg::CoordW-1:0]         cfg_wdata_i,
  input  logic                                in_valid_i,
  input  logic                                in_stall_i,
  input  logic signed [cgbp_pkg::PosW-1:0]    pos_x_i,
  input  logic signed [cgbp_pkg::PosW-1:0]    pos_y_i,
  input  logic [cgbp_pkg::SizeW-1:0]          glyph_width_i,
  input  logic [cgbp_pkg::SizeW-1:0]          glyph_height_i,
  input  logic [cgbp_pkg::AddrW-1:0]          bitmap_offset_i,
  input  logic [cgbp_pkg::AlphaW-1:0]         alpha_level_i,
  input  logic                                out_valid_i,
  input  logic                                out_stall_i,
  input  logic [cgbp_pkg::CoordW-1:0]         dest_x_i,
  input  logic [cgbp_pkg::CoordW-1:0]         dest_y_i,
  input  logic [cgbp_pkg::SizeW-1:0]          rect_width_i,
  input  logic [cgbp_pkg::SizeW-1:0]          rect_height_i,
  input  logic [cgbp_pkg::AddrW-1:0]          source_address_i,
  input  logic                                half_byte_start_i,
  input  logic [cgbp_pkg::AlphaW-1:0]         palette_select_i,
  input  logic                                last_command_i,
  output int                                  pending_o,
  output int                                  mismatch_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [cgbp_pkg::CoordW-1:0] dest_x;
    logic [cgbp_pkg::CoordW-1:0] dest_y;
    logic [cgbp_pkg::SizeW-1:0]  rect_width;
    logic [cgbp_pkg::SizeW-1:0]  rect_height;
    logic [cgbp_pkg::AddrW-1:0]  source_address;
    logic                        half_byte_start;
    logic [cgbp_pkg::AlphaW-1:0] palette_select;
    logic                        last_command;
  } blit_cmd_t;

  blit_cmd_t                   blit_cmd_q[$];
  logic [cgbp_pkg::CoordW-1:0] screen_w;
  logic [cgbp_pkg::CoordW-1:0] screen_h;
  int                          mismatch_cnt;

  function automatic int int_max(int a, int b);
    return (a > b) ? a : b;
  endfunction

  function automatic int int_min(int a, int b);
    return (a < b) ? a : b;
  endfunction

  task automatic show_cmd(input string tag, input blit_cmd_t c);
    $display("%0t: %s dx=%0d dy=%0d w=%0d h=%0d src=%h half=%b pal=%0d last=%b",
             $realtime, tag, c.dest_x, c.dest_y, c.rect_width, c.rect_height,
             c.source_address, c.half_byte_start, c.palette_select, c.last_command);
  endtask

  task automatic plan_blit(input logic signed [cgbp_pkg::PosW-1:0] px,
                           input logic signed [cgbp_pkg::PosW-1:0] py,
                           input logic [cgbp_pkg::SizeW-1:0] gw,
                           input logic [cgbp_pkg::SizeW-1:0] gh,
                           input logic [cgbp_pkg::AddrW-1:0] offset,
                           input logic [cgbp_pkg::AlphaW-1:0] alpha);
    int        x, y, w, h, sw, sh;
    int        xo, yo, skip_x, skip_y, sx, sy, row_bytes, col, r;
    logic [cgbp_pkg::AlphaW-1:0] pal;
    blit_cmd_t c;
    x  = px;
    y  = py;
    w  = gw;
    h  = gh;
    sw = screen_w;
    sh = screen_h;
    if (h > MAX_GLYPH_HEIGHT) h = MAX_GLYPH_HEIGHT;
    pal = alpha;
    if (int'(alpha) >= ALPHA_LEVELS) pal = cgbp_pkg::AlphaW'(ALPHA_LEVELS - 1);
    row_bytes = (w >> 1) + (w & 1);
    xo = int_max(0, int_min(sw, x + w) - int_max(0, x));
    yo = int_max(0, int_min(sh, y + h) - int_max(0, y));
    skip_x = int_max(0, -x);
    skip_y = int_max(0, -y);
    sx = int_max(x, 0);
    sy = int_max(y, 0);
    if (xo > 0 && yo > 0) begin
      c.dest_x         = cgbp_pkg::CoordW'(sx);
      c.rect_width     = cgbp_pkg::SizeW'(xo);
      c.palette_select = pal;
      if (xo == w) begin
        c.dest_y          = cgbp_pkg::CoordW'(sy);
        c.rect_height     = cgbp_pkg::SizeW'(yo);
        c.source_address  = cgbp_pkg::AddrW'(int'(offset) + skip_y * row_bytes);
        c.half_byte_start = 1'b0;
        c.last_command    = 1'b1;
        blit_cmd_q.push_back(c);
      end else begin
        col = skip_x >> 1;
        for (r = 0; r < yo && r < MAX_GLYPH_HEIGHT; r++) begin
          c.dest_y          = cgbp_pkg::CoordW'(sy + r);
          c.rect_height     = cgbp_pkg::SizeW'(1);
          c.source_address  =
            cgbp_pkg::AddrW'(int'(offset) + (skip_y + r) * row_bytes + col);
          c.half_byte_start = skip_x[0];
          c.last_command    = (r == yo - 1);
          blit_cmd_q.push_back(c);
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    blit_cmd_t got, want;
    if (!rst_ni) begin
      screen_w = cgbp_pkg::SCREEN_WIDTH_RESET;
      screen_h = cgbp_pkg::SCREEN_HEIGHT_RESET;
      blit_cmd_q.delete();
      mismatch_cnt = 0;
      pending_o  <= 0;
      mismatch_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got = '{dest_x_i, dest_y_i, rect_width_i, rect_height_i, source_address_i,
                half_byte_start_i, palette_select_i, last_command_i};
        if (blit_cmd_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) show_cmd("unexpected word", got);
        end else begin
          want = blit_cmd_q.pop_front();
          if (got !== want) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
              show_cmd("mismatch exp", want);
              show_cmd("         got", got);
            end
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          cgbp_pkg::CFG_SCREEN_WIDTH:  screen_w = cfg_wdata_i;
          cgbp_pkg::CFG_SCREEN_HEIGHT: screen_h = cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i)
        plan_blit(pos_x_i, pos_y_i, glyph_width_i, glyph_height_i, bitmap_offset_i,
                  alpha_level_i);
      pending_o  <= blit_cmd_q.size();
      mismatch_o <= mismatch_cnt;
    end
  end

endmodule

/* sim/tb_clipped_glyph_blit_planner_core.sv */
// ----------------------------------------------------------------------------
// tb_clipped_glyph_blit_planner_core: stimulus and verdict for the planner
// Sends directed placements (edges, clips, wrap, saturation, empty glyphs)
// and then random placements aimed at the screen borders, over several
// screen sizes including the extremes, with random idling on both channels
// and one long output hold-off. The checker instance predicts and compares.
// ----------------------------------------------------------------------------
module tb_clipped_glyph_blit_planner_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxGlyphH  = 64;
  localparam int unsigned AlphaLvls  = 16;
  localparam int          StallLimit = 5000;
  localparam int          HoldCycles = 300;

  logic                              clk_i;
  logic                              rst_ni;
  logic                              cfg_we_i;
  logic [cgbp_pkg::CfgIdxW-1:0]      cfg_idx_i;
  logic [cgbp_pkg::CoordW-1:0]       cfg_wdata_i;
  logic                              in_valid_i;
  logic                              in_stall_o;
  logic signed [cgbp_pkg::PosW-1:0]  pos_x_i;
  logic signed [cgbp_pkg::PosW-1:0]  pos_y_i;
  logic [cgbp_pkg::SizeW-1:0]        glyph_width_i;
  logic [cgbp_pkg::SizeW-1:0]        glyph_height_i;
  logic [cgbp_pkg::AddrW-1:0]        bitmap_offset_i;
  logic [cgbp_pkg::AlphaW-1:0]       alpha_level_i;
  logic                              out_valid_o;
  logic                              out_stall_i;
  logic [cgbp_pkg::CoordW-1:0]       dest_x_o;
  logic [cgbp_pkg::CoordW-1:0]       dest_y_o;
  logic [cgbp_pkg::SizeW-1:0]        rect_width_o;
  logic [cgbp_pkg::SizeW-1:0]        rect_height_o;
  logic [cgbp_pkg::AddrW-1:0]        source_address_o;
  logic                              half_byte_start_o;
  logic [cgbp_pkg::AlphaW-1:0]       palette_select_o;
  logic                              last_command_o;

  int pending_cmds;
  int mismatch_cnt;
  int glyphs_sent;
  int words_seen;
  int screens_used;
  int quiet_cycles;
  int scr_w;
  int scr_h;
  bit idle_on;
  bit hold_request;

  clipped_glyph_blit_planner_core #(
    .MAX_GLYPH_HEIGHT(MaxGlyphH),
    .ALPHA_LEVELS    (AlphaLvls)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .pos_x_i          (pos_x_i),
    .pos_y_i          (pos_y_i),
    .glyph_width_i    (glyph_width_i),
    .glyph_height_i   (glyph_height_i),
    .bitmap_offset_i  (bitmap_offset_i),
    .alpha_level_i    (alpha_level_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .dest_x_o         (dest_x_o),
    .dest_y_o         (dest_y_o),
    .rect_width_o     (rect_width_o),
    .rect_height_o    (rect_height_o),
    .source_address_o (source_address_o),
    .half_byte_start_o(half_byte_start_o),
    .palette_select_o (palette_select_o),
    .last_command_o   (last_command_o)
  );

  cgbp_blit_checker #(
    .MAX_GLYPH_HEIGHT(MaxGlyphH),
    .ALPHA_LEVELS    (AlphaLvls)
  ) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .pos_x_i          (pos_x_i),
    .pos_y_i          (pos_y_i),
    .glyph_width_i    (glyph_width_i),
    .glyph_height_i   (glyph_height_i),
    .bitmap_offset_i  (bitmap_offset_i),
    .alpha_level_i    (alpha_level_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .dest_x_i         (dest_x_o),
    .dest_y_i         (dest_y_o),
    .rect_width_i     (rect_width_o),
    .rect_height_i    (rect_height_o),
    .source_address_i (source_address_o),
    .half_byte_start_i(half_byte_start_o),
    .palette_select_i (palette_select_o),
    .last_command_i   (last_command_o),
    .pending_o        (pending_cmds),
    .mismatch_o       (mismatch_cnt)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // output side: random stall, plus one long hold-off on request
  initial begin
    int hold_left;
    hold_left   = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left == 0 && hold_request) begin
        hold_left    = HoldCycles;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= idle_on && ($urandom_range(99) < 9);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) words_seen++;
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("Timeout after %0d cycles without a handshake", quiet_cycles);
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [cgbp_pkg::CfgIdxW-1:0] idx, input int value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= cgbp_pkg::CoordW'(value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_screen(input int w, input int h);
    write_reg(cgbp_pkg::CFG_SCREEN_WIDTH, w);
    write_reg(cgbp_pkg::CFG_SCREEN_HEIGHT, h);
    scr_w = w;
    scr_h = h;
    screens_used++;
  endtask

  // drop valid and wait until every command word has been taken
  task automatic drain_commands();
    in_valid_i <= 1'b0;
    while (pending_cmds != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic send_glyph(input int x, input int y, input int w, input int h,
                            input int offset, input int alpha);
    while (idle_on && ($urandom_range(99) < 9)) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    pos_x_i         <= cgbp_pkg::PosW'(x);
    pos_y_i         <= cgbp_pkg::PosW'(y);
    glyph_width_i   <= cgbp_pkg::SizeW'(w);
    glyph_height_i  <= cgbp_pkg::SizeW'(h);
    bitmap_offset_i <= cgbp_pkg::AddrW'(offset);
    alpha_level_i   <= cgbp_pkg::AlphaW'(alpha);
    do @(posedge clk_i); while (in_stall_o);
    glyphs_sent++;
    @(negedge clk_i);
  endtask

  // mostly placements around the screen borders, some pure noise
  task automatic send_random_glyph();
    int x, y, w, h;
    if ($urandom_range(99) < 80) begin
      w = $urandom_range(16, 1);
      h = $urandom_range(12, 1);
      if ($urandom_range(9) == 0) w = $urandom_range(127);
      if ($urandom_range(19) == 0) h = $urandom_range(127);
      x = $urandom_range(scr_w + w + 8) - w - 4;
      y = $urandom_range(scr_h + h + 8) - h - 4;
    end else begin
      w = $urandom_range(127);
      h = $urandom_range(127);
      x = $urandom_range(2047) - 1024;
      y = $urandom_range(2047) - 1024;
    end
    send_glyph(x, y, w, h, $urandom_range(65535), $urandom_range(15));
  endtask

  initial begin
    int phase, n, w, h;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = cgbp_pkg::CFG_SCREEN_WIDTH;
    cfg_wdata_i     = '0;
    in_valid_i      = 1'b0;
    pos_x_i         = '0;
    pos_y_i         = '0;
    glyph_width_i   = '0;
    glyph_height_i  = '0;
    bitmap_offset_i = '0;
    alpha_level_i   = '0;
    glyphs_sent     = 0;
    words_seen      = 0;
    screens_used    = 1;
    quiet_cycles    = 0;
    scr_w           = cgbp_pkg::SCREEN_WIDTH_RESET;
    scr_h           = cgbp_pkg::SCREEN_HEIGHT_RESET;
    idle_on         = 1'b1;
    hold_request    = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset screen of 240 by 320
    send_glyph(10, 10, 8, 8, 'h0100, 3);
    send_glyph(20, -3, 5, 10, 'h0200, 0);
    send_glyph(100, 315, 6, 10, 'h0300, 15);
    send_glyph(-3, 40, 9, 4, 'h0400, 7);
    send_glyph(-2, 60, 8, 3, 'h0500, 8);
    send_glyph(236, 80, 10, 3, 'h0600, 1);
    send_glyph(-20, 5, 10, 5, 'h0700, 2);
    send_glyph(240, 5, 10, 5, 'h0800, 2);
    send_glyph(5, -64, 8, 64, 'h0900, 4);
    send_glyph(5, -63, 8, 64, 'h0a00, 4);
    send_glyph(30, 30, 0, 8, 'h0b00, 5);
    send_glyph(30, 30, 8, 0, 'h0c00, 5);
    send_glyph(50, 50, 9, 100, 'h0d00, 6);
    send_glyph(200, 200, 127, 127, 'hffff, 15);
    send_glyph(0, 0, 127, 2, 'h0000, 0);
    send_glyph(-5, -10, 7, 20, 'hfff0, 9);
    send_glyph(-1024, -1024, 64, 64, 'h1234, 10);
    send_glyph(1023, 1023, 64, 64, 'h4321, 11);
    send_glyph(-1, 100, 64, 64, 'hffc0, 12);
    drain_commands();

    set_screen(1, 1);
    send_glyph(0, 0, 3, 2, 'h0010, 1);
    send_glyph(0, 0, 1, 1, 'h0020, 2);
    drain_commands();

    set_screen(1023, 1023);
    send_glyph(1000, 1000, 64, 64, 'h8000, 13);
    send_glyph(-1, -1, 127, 64, 'hfffe, 14);
    drain_commands();

    set_screen(0, 500);
    send_glyph(0, 0, 4, 4, 'h0040, 3);
    drain_commands();
    set_screen(500, 0);
    send_glyph(0, 0, 4, 4, 'h0050, 3);
    drain_commands();

    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin w = 240; h = 320; end
        1: begin w = 1023; h = 1023; end
        2: begin w = 1; h = 1; end
        3: begin w = $urandom_range(1023, 1); h = $urandom_range(1023, 1); end
        4: begin w = 0; h = $urandom_range(1023); end
        5: begin w = $urandom_range(1023); h = 0; end
        6: begin w = $urandom_range(40, 1); h = $urandom_range(40, 1); end
        default: begin
          w = cgbp_pkg::SCREEN_WIDTH_RESET;
          h = cgbp_pkg::SCREEN_HEIGHT_RESET;
        end
      endcase
      set_screen(w, h);
      idle_on = (phase != 1);
      if (phase == 0) hold_request = 1'b1;
      for (n = 0; n < 50; n++) send_random_glyph();
      drain_commands();
    end
    idle_on = 1'b1;
    repeat (20) @(negedge clk_i);

    $display("Sent %0d glyph placements over %0d screen settings, %0d command words checked",
             glyphs_sent, screens_used, words_seen);
    $display("Random stalls on both channels and one %0d-cycle output hold-off", HoldCycles);
    if (mismatch_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", mismatch_cnt);
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
design/cgbp_pkg.sv
design/cgbp_ctrl.sv
design/cgbp_datapath.sv
design/clipped_glyph_blit_planner_core.sv
sim/cgbp_blit_checker.sv
sim/tb_clipped_glyph_blit_planner_core.sv
